/* rtl/rse_pkg.sv */
// Shared constants and codes for the reverse Polish stack evaluator.
`default_nettype none
package rse_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned DEPTH_W     = 8;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd3;

endpackage
`default_nettype wire

/* rtl/rse_alu.sv */
// Combinational add, subtract and low-word multiply for the stack evaluator.
`default_nettype none
module rse_alu (
  input  wire logic [rse_pkg::CMD_W-1:0]  op_i,
  input  wire logic [rse_pkg::WORD_W-1:0] lhs_i,
  input  wire logic [rse_pkg::WORD_W-1:0] rhs_i,
  output logic      [rse_pkg::WORD_W-1:0] result_o
);

  logic [rse_pkg::WORD_W-1:0] product;

  assign product = lhs_i * rhs_i;

  always_comb begin
    case (op_i)
      rse_pkg::CMD_ADD: result_o = lhs_i + rhs_i;
      rse_pkg::CMD_SUB: result_o = lhs_i - rhs_i;
      rse_pkg::CMD_MUL: result_o = product;
      default:          result_o = lhs_i + rhs_i;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rse_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module rse_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rse_pkg::WORD_W-1:0]  dividend_i,
  input  wire logic [rse_pkg::WORD_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [rse_pkg::WORD_W-1:0]  quotient_o
);

  localparam int unsigned W  = rse_pkg::WORD_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  den_q;
  logic          neg_q;

  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [W:0]   rem_shift;
  logic [W:0]   trial;

  assign mag_a     = dividend_i[W-1] ? (W'(0) - dividend_i) : dividend_i;
  assign mag_b     = divisor_i[W-1]  ? (W'(0) - divisor_i)  : divisor_i;
  assign rem_shift = {rem_q, quo_q[W-1]};
  assign trial     = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= mag_a;
        den_q  <= mag_b;
        neg_q  <= dividend_i[W-1] ^ divisor_i[W-1];
      end else if (busy_q) begin
        if (!trial[W]) begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= rem_shift[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

/* rtl/rpn_stack_evaluator.sv */
// Reverse Polish stack evaluator: top level with operand stack and sequencer.
//
// Input channel: in_valid_i / in_ready_o carry one token word (cmd_i, number_i).
// Output channel: out_valid_o / out_ready_i carry one result word per token
// (top_value_o, has_value_o, depth_o, status_o), in token order.
// The top of stack sits in a register; deeper entries live in a memory of
// STACK_DEPTH words with one write port and a registered read port.
// Sequencer states per token between S_IDLE and S_DONE:
//   push and no-op codes: none
//   add, subtract, multiply, finish, divide by zero: S_OPER (one stack read)
//   divide: S_OPER, then S_DIV for the one-bit-per-cycle divider
// in_ready_o is high only while the sequencer is idle; one token is in work
// at a time. A finished result waits in the output register, and the next
// token is accepted and worked on meanwhile; its result is held back until
// the output register is taken.
// Reset empties the stack and drops any pending result; stack memory contents
// are not cleared, and a word read from them is used only once it has been written.
`default_nettype none
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = rse_pkg::STACK_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rse_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [rse_pkg::WORD_W-1:0]    number_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [rse_pkg::WORD_W-1:0]    top_value_o,
  output logic                               has_value_o,
  output logic      [rse_pkg::DEPTH_W-1:0]   depth_o,
  output logic      [rse_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned W  = rse_pkg::WORD_W;
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = rse_pkg::DEPTH_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;

  logic [W-1:0]                  mem [STACK_DEPTH];
  logic [W-1:0]                  rd_q;
  logic [LW-1:0]                 level_q;
  logic [W-1:0]                  top_q;
  logic [rse_pkg::CMD_W-1:0]     cmd_q;
  logic [W-1:0]                  res_value_q;
  logic                          res_has_q;
  logic [rse_pkg::STATUS_W-1:0]  res_status_q;

  logic                          out_valid_q;
  logic [W-1:0]                  out_value_q;
  logic                          out_has_q;
  logic [DW-1:0]                 out_depth_q;
  logic [rse_pkg::STATUS_W-1:0]  out_status_q;

  logic           accept;
  logic           full;
  logic           have_r;
  logic           have_l;
  logic [W-1:0]   rhs;
  logic [W-1:0]   lhs;
  logic [W-1:0]   alu_y;
  logic           wr_en;
  logic [AW-1:0]  wr_lvl;
  logic [AW-1:0]  rd_lvl;
  logic           div_start;
  logic           div_done;
  logic [W-1:0]   div_q;
  logic [LW+DW-1:0] level_ext;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign full      = (level_q == LW'(STACK_DEPTH));
  assign have_r    = (level_q != '0);
  assign have_l    = (level_q > LW'(1));
  assign rhs       = have_r ? top_q : '0;
  assign lhs       = have_l ? rd_q  : '0;
  assign wr_en     = accept && (cmd_i == rse_pkg::CMD_PUSH) && have_r && !full;
  assign wr_lvl    = AW'(level_q - LW'(1));
  assign rd_lvl    = AW'(level_q - LW'(2));
  assign div_start = (state_q == S_OPER) && (cmd_q == rse_pkg::CMD_DIV) && (rhs != '0);
  assign level_ext = {{DW{1'b0}}, level_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_lvl] <= top_q;
    end
    rd_q <= mem[rd_lvl];
  end

  rse_alu u_alu (
    .op_i     (cmd_q),
    .lhs_i    (lhs),
    .rhs_i    (rhs),
    .result_o (alu_y)
  );

  rse_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lhs),
    .divisor_i  (rhs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_i;
            case (cmd_i)
              rse_pkg::CMD_PUSH: begin
                if (full) begin
                  res_value_q  <= top_q;
                  res_has_q    <= have_r;
                  res_status_q <= rse_pkg::ST_FULL;
                end else begin
                  top_q        <= number_i;
                  level_q      <= level_q + LW'(1);
                  res_value_q  <= number_i;
                  res_has_q    <= 1'b1;
                  res_status_q <= rse_pkg::ST_OK;
                end
                state_q <= S_DONE;
              end
              rse_pkg::CMD_ADD, rse_pkg::CMD_SUB, rse_pkg::CMD_MUL,
              rse_pkg::CMD_DIV, rse_pkg::CMD_FINISH: begin
                state_q <= S_OPER;
              end
              default: begin
                res_value_q  <= rhs;
                res_has_q    <= have_r;
                res_status_q <= rse_pkg::ST_OK;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_OPER: begin
          case (cmd_q)
            rse_pkg::CMD_DIV: begin
              if (rhs == '0) begin
                level_q      <= have_r ? (level_q - LW'(1)) : '0;
                top_q        <= rd_q;
                res_value_q  <= lhs;
                res_has_q    <= have_l;
                res_status_q <= rse_pkg::ST_DIV_ZERO;
                state_q      <= S_DONE;
              end else begin
                level_q      <= have_l ? (level_q - LW'(1)) : LW'(1);
                res_status_q <= have_l ? rse_pkg::ST_OK : rse_pkg::ST_EMPTY;
                state_q      <= S_DIV;
              end
            end
            rse_pkg::CMD_FINISH: begin
              if (have_r) begin
                level_q <= level_q - LW'(1);
                top_q   <= rd_q;
              end
              res_value_q  <= rhs;
              res_has_q    <= have_r;
              res_status_q <= rse_pkg::ST_OK;
              state_q      <= S_DONE;
            end
            default: begin
              top_q        <= alu_y;
              level_q      <= have_l ? (level_q - LW'(1)) : LW'(1);
              res_value_q  <= alu_y;
              res_has_q    <= 1'b1;
              res_status_q <= have_l ? rse_pkg::ST_OK : rse_pkg::ST_EMPTY;
              state_q      <= S_DONE;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            top_q       <= div_q;
            res_value_q <= div_q;
            res_has_q   <= 1'b1;
            state_q     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= res_value_q;
            out_has_q    <= res_has_q;
            out_depth_q  <= level_ext[DW-1:0];
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign top_value_o = out_value_q;
  assign has_value_o = out_has_q;
  assign depth_o     = out_depth_q;
  assign status_o    = out_status_q;

endmodule
`default_nettype wire

/* tb/rpn_stack_evaluator_tb.sv */
// Self-checking testbench for the reverse Polish stack evaluator.
`default_nettype none
module rpn_stack_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rse_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int TOKEN_TARGET  = 775;
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] number;
  } token_t;

  typedef struct packed {
    logic [WORD_W-1:0]   top_value;
    logic                has_value;
    logic [DEPTH_W-1:0]  depth;
    logic [STATUS_W-1:0] status;
  } result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i = CMD_PUSH;
  logic [WORD_W-1:0]   number_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [WORD_W-1:0]   top_value_o;
  logic                has_value_o;
  logic [DEPTH_W-1:0]  depth_o;
  logic [STATUS_W-1:0] status_o;

  token_t  pending_tokens[$];
  result_t predicted_results[$];
  int      total_tokens = 0;
  int      accepted_tokens = 0;
  int      checked_results = 0;
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      timed_out = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;

  logic [WORD_W-1:0] calc_stack [STACK_DEPTH];
  int unsigned       calc_level = 0;
  logic [STATUS_W-1:0] calc_status = ST_OK;

  rpn_stack_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .top_value_o (top_value_o),
    .has_value_o (has_value_o),
    .depth_o     (depth_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void push_operand(logic [WORD_W-1:0] value);
    if (calc_level < STACK_DEPTH) begin
      calc_stack[calc_level] = value;
      calc_level++;
    end else begin
      calc_status = ST_FULL;
    end
  endfunction

  function automatic logic [WORD_W-1:0] pop_operand();
    if (calc_level > 0) begin
      calc_level--;
      return calc_stack[calc_level];
    end
    calc_status = ST_EMPTY;
    return '0;
  endfunction

  function automatic logic [WORD_W-1:0] div_toward_zero(logic [WORD_W-1:0] a,
                                                        logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] mag_a, mag_b, quot;
    mag_a = a[WORD_W-1] ? ('0 - a) : a;
    mag_b = b[WORD_W-1] ? ('0 - b) : b;
    quot  = mag_a / mag_b;
    return (a[WORD_W-1] != b[WORD_W-1]) ? ('0 - quot) : quot;
  endfunction

  function automatic result_t evaluate_token(logic [CMD_W-1:0] cmd,
                                             logic [WORD_W-1:0] number);
    logic [WORD_W-1:0] rhs, lhs, product;
    result_t res;
    bit finished;
    res = '0;
    finished = 1'b0;
    calc_status = ST_OK;
    case (cmd)
      CMD_PUSH: push_operand(number);
      CMD_ADD: begin
        rhs = pop_operand();
        lhs = pop_operand();
        push_operand(lhs + rhs);
      end
      CMD_SUB: begin
        rhs = pop_operand();
        lhs = pop_operand();
        push_operand(lhs - rhs);
      end
      CMD_MUL: begin
        rhs = pop_operand();
        lhs = pop_operand();
        product = lhs * rhs;
        push_operand(product);
      end
      CMD_DIV: begin
        rhs = pop_operand();
        if (rhs == '0) begin
          calc_status = ST_DIV_ZERO;
        end else begin
          lhs = pop_operand();
          push_operand(div_toward_zero(lhs, rhs));
        end
      end
      CMD_FINISH: begin
        finished = 1'b1;
        if (calc_level > 0) begin
          res.top_value = pop_operand();
          res.has_value = 1'b1;
        end
      end
      default: ;
    endcase
    if (!finished && calc_level > 0) begin
      res.top_value = calc_stack[calc_level-1];
      res.has_value = 1'b1;
    end
    res.depth  = calc_level[DEPTH_W-1:0];
    res.status = calc_status;
    return res;
  endfunction

  function automatic void add_token(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] number);
    token_t tok;
    tok.cmd    = cmd;
    tok.number = number;
    pending_tokens.push_back(tok);
  endfunction

  function automatic logic [WORD_W-1:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return WORD_W'($signed($urandom_range(0, 40)) - 20);
    if (sel < 60) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_arith();
    case ($urandom_range(0, 3))
      0: return CMD_ADD;
      1: return CMD_SUB;
      2: return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  function automatic void add_expression();
    int ops_left, pushes_left, level;
    ops_left    = $urandom_range(1, 6);
    pushes_left = ops_left + 1;
    level       = 0;
    while (pushes_left > 0 || ops_left > 0) begin
      if (pushes_left > 0 && (level < 2 || $urandom_range(0, 1) == 0)) begin
        add_token(CMD_PUSH, pick_operand());
        pushes_left--;
        level++;
      end else begin
        add_token(pick_arith(), $urandom);
        ops_left--;
        level--;
      end
    end
    add_token(CMD_FINISH, $urandom);
  endfunction

  function automatic int sender_idle_pct(int done);
    if (done < total_tokens / 3) return 21;
    if (done < 2 * total_tokens / 3) return 83;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(int done);
    if (done < total_tokens / 3) return 83;
    if (done < 2 * total_tokens / 3) return 21;
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i      <= CMD_PUSH;
      number_i   <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predicted_results.push_back(evaluate_token(cmd_i, number_i));
        void'(pending_tokens.pop_front());
        accepted_tokens++;
      end
      if (pending_tokens.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct(accepted_tokens)) begin
        in_valid_i <= 1'b1;
        cmd_i      <= pending_tokens[0].cmd;
        number_i   <= pending_tokens[0].number;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (!hold_done && accepted_tokens >= total_tokens - total_tokens / 4) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(0, 99) >= receiver_idle_pct(accepted_tokens);
    end
  end

  always @(posedge clk_i) begin
    result_t seen, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{top_value_o, has_value_o, depth_o, status_o};
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result word: top=%h has=%b depth=%0d status=%0d",
                   seen.top_value, seen.has_value, seen.depth, seen.status);
      end else begin
        want = predicted_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("word %0d: expected top=%h has=%b depth=%0d status=%0d,",
                     checked_results, want.top_value, want.has_value, want.depth,
                     want.status,
                     " got top=%h has=%b depth=%0d status=%0d",
                     seen.top_value, seen.has_value, seen.depth, seen.status);
        end
      end
      checked_results++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT)
        timed_out <= 1'b1;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit filled;
    int burst;
    filled = 1'b0;

    add_token(CMD_FINISH, 32'h0000_0000);
    add_token(CMD_ADD, 32'hFFFF_FFFF);
    add_token(CMD_FINISH, 32'h0000_0000);
    add_token(CMD_DIV, 32'h0000_0000);
    add_token(CMD_PUSH, 32'h7FFF_FFFF);
    add_token(CMD_PUSH, 32'h0000_0001);
    add_token(CMD_ADD, 32'h0000_0000);
    add_token(CMD_PUSH, 32'hFFFF_FFFF);
    add_token(CMD_DIV, 32'h0000_0000);
    add_token(CMD_PUSH, 32'h0000_0000);
    add_token(CMD_DIV, 32'h0000_0000);
    add_token(CMD_PUSH, 32'hFFFF_FFF9);
    add_token(CMD_PUSH, 32'h0000_0002);
    add_token(CMD_DIV, 32'h0000_0000);
    add_token(CMD_MUL, 32'h0000_0000);
    add_token(CMD_PUSH, 32'h0000_0005);
    add_token(CMD_SUB, 32'h0000_0000);
    add_token(CMD_SPARE_A, 32'h5555_5555);
    add_token(CMD_SPARE_B, 32'hAAAA_AAAA);
    add_token(CMD_FINISH, 32'h0000_0000);
    add_token(CMD_MUL, 32'h0000_0000);
    add_token(CMD_PUSH, 32'h8000_0000);
    add_token(CMD_SUB, 32'h0000_0000);
    add_token(CMD_FINISH, 32'h0000_0000);
    add_token(CMD_FINISH, 32'h0000_0000);

    while (pending_tokens.size() < TOKEN_TARGET) begin
      if (!filled && pending_tokens.size() > 300) begin
        filled = 1'b1;
        repeat (STACK_DEPTH + 2) add_token(CMD_PUSH, pick_operand());
        add_expression();
        repeat (STACK_DEPTH + 2) add_token(pick_arith(), $urandom);
        add_token(CMD_FINISH, $urandom);
      end else if ($urandom_range(0, 99) < 80) begin
        add_expression();
      end else begin
        burst = $urandom_range(1, 3);
        repeat (burst) add_token(CMD_W'($urandom_range(0, 7)), $urandom);
      end
    end
    total_tokens = pending_tokens.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_tokens.size() != 0 || predicted_results.size() != 0) && !timed_out)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && predicted_results.size() == 0 && !timed_out)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/rse_pkg.sv
rtl/rse_alu.sv
rtl/rse_divider.sv
rtl/rpn_stack_evaluator.sv
tb/rpn_stack_evaluator_tb.sv
